>>> rtl/core/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, codes and character constants for the token scanner.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Default width of the internal row and column counters
  localparam int POS_BITS_DEF = 16;

  // Result queue depth; one scanned byte pushes at most two records
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Scanner modes
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_INT     = 4'd2,
    M_STR     = 4'd3,
    M_IDENT   = 4'd4,
    M_CMD     = 4'd5,
    M_BLOCK   = 4'd6,
    M_COLON   = 4'd7,
    M_EQ      = 4'd8,
    M_REL     = 4'd9
  } mode_t;

  // Token kinds
  localparam logic [3:0] K_INT    = 4'd0;
  localparam logic [3:0] K_STR    = 4'd1;
  localparam logic [3:0] K_IDENT  = 4'd2;
  localparam logic [3:0] K_CMD    = 4'd3;
  localparam logic [3:0] K_BLOCK  = 4'd4;
  localparam logic [3:0] K_LP     = 4'd5;
  localparam logic [3:0] K_RP     = 4'd6;
  localparam logic [3:0] K_ADD    = 4'd7;
  localparam logic [3:0] K_MUL    = 4'd8;
  localparam logic [3:0] K_ASSIGN = 4'd9;
  localparam logic [3:0] K_EQU    = 4'd10;
  localparam logic [3:0] K_REL    = 4'd11;
  localparam logic [3:0] K_EOF    = 4'd12;

  // Error codes
  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_BAD_CHAR   = 3'd1;
  localparam logic [2:0] E_OPEN_STR   = 3'd2;
  localparam logic [2:0] E_EMPTY_ID   = 3'd3;
  localparam logic [2:0] E_EMPTY_CMD  = 3'd4;
  localparam logic [2:0] E_OPEN_BLOCK = 3'd5;
  localparam logic [2:0] E_BAD_COLON  = 3'd6;
  localparam logic [2:0] E_BAD_EQU    = 3'd7;

  // Characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // One result record
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text_char;
    logic        has_char;
    logic        first;
    logic        last;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  error;
  } rec_t;

  // Push request from the scanner into the result queue
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

endpackage

>>> rtl/core/tks_if.sv
// ----------------------------------------------------------------------------
// tks_if
// Valid/ready channels: source bytes in, token records out.
// ----------------------------------------------------------------------------
interface tks_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface tks_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  text_char;
  logic        has_char;
  logic        first;
  logic        last;
  logic [15:0] row;
  logic [15:0] col;
  logic [2:0]  error;

  modport source (output valid, output kind, output text_char, output has_char,
                  output first, output last, output row, output col,
                  output error, input ready);
  modport sink (input valid, input kind, input text_char, input has_char,
                input first, input last, input row, input col,
                input error, output ready);
endinterface

>>> rtl/core/tks_outq.sv
// ----------------------------------------------------------------------------
// tks_outq
// Result queue: takes up to two records a cycle, sends one a cycle when ready.
// ----------------------------------------------------------------------------
module tks_outq (
  input  logic           clk,
  input  logic           rst,
  input  tks_pkg::push_t push,
  output logic           room,
  tks_tok_if.source      tokens
);
  import tks_pkg::*;

  rec_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;
  rec_t                head;

  // Space for a full two-record request
  assign room = count <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign pop  = tokens.valid && tokens.ready;
  assign head = mem[rd_ptr];

  // Record storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.v0) + OQ_PTR_W'(push.v1);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + OQ_CNT_W'(push.v0) + OQ_CNT_W'(push.v1) - OQ_CNT_W'(pop);
    end
  end

  // Head of queue drives the output channel
  assign tokens.valid     = count != '0;
  assign tokens.kind      = head.kind;
  assign tokens.text_char = head.text_char;
  assign tokens.has_char  = head.has_char;
  assign tokens.first     = head.first;
  assign tokens.last      = head.last;
  assign tokens.row       = head.row;
  assign tokens.col       = head.col;
  assign tokens.error     = head.error;

endmodule

>>> rtl/core/tks_core.sv
// ----------------------------------------------------------------------------
// tks_core
// Scanner state and the single-pass step: one byte in, up to two records out.
// ----------------------------------------------------------------------------
module tks_core #(
  parameter int POS_BITS = tks_pkg::POS_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [7:0]     ch,
  input  logic           eoi,
  output tks_pkg::push_t push
);
  import tks_pkg::*;

  localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;

  typedef logic [POS_BITS-1:0] pos_t;

  mode_t      mode, mode_next;
  pos_t       cur_row, cur_col, start_row, start_col;
  pos_t       row_next, col_next, srow_next, scol_next;
  pos_t       arow, acol;
  logic [7:0] held_char, held_next;
  logic       name_empty, empty_next;
  logic       halted, halted_next;

  logic       a0v, a1v, bv, fall;
  rec_t       a0, a1, b;
  logic [3:0] tkind;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CH_UNDER;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Report positions capped at 16 bits
  function automatic logic [15:0] cap(pos_t v);
    logic [PW-1:0] e;
    e = PW'(v);
    return (e > PW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic rec_t mk(logic [3:0] k, logic [7:0] c, logic has, logic f,
                              logic l, pos_t r, pos_t cl, logic [2:0] err);
    rec_t x;
    x.kind      = k;
    x.text_char = c;
    x.has_char  = has;
    x.first     = f;
    x.last      = l;
    x.row       = cap(r);
    x.col       = cap(cl);
    x.error     = err;
    return x;
  endfunction

  // Position after the current byte, saturating
  always_comb begin
    arow = cur_row;
    acol = cur_col;
    if (ch == CH_LF) begin
      if (cur_row != '1) arow = cur_row + POS_BITS'(1);
      acol = POS_BITS'(1);
    end else if (cur_col != '1) begin
      acol = cur_col + POS_BITS'(1);
    end
  end

  // Step logic
  always_comb begin
    mode_next   = mode;
    row_next    = cur_row;
    col_next    = cur_col;
    srow_next   = start_row;
    scol_next   = start_col;
    held_next   = held_char;
    empty_next  = name_empty;
    halted_next = halted;
    a0v  = 1'b0;
    a1v  = 1'b0;
    bv   = 1'b0;
    fall = 1'b0;
    a0   = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b0, start_row, start_col, E_NONE);
    a1   = a0;
    b    = a0;
    tkind = K_INT;

    if (!halted) begin
      // Pending token of the current mode
      case (mode)
        M_COMMENT: begin
          if (!eoi) begin
            row_next = arow;
            col_next = acol;
            if (ch == CH_LF) mode_next = M_IDLE;
          end else begin
            mode_next = M_IDLE;
            fall      = 1'b1;
          end
        end
        M_INT: begin
          a0v = 1'b1;
          if (!eoi && is_digit(ch)) begin
            a0       = mk(K_INT, ch, 1'b1, 1'b0, 1'b0, start_row, start_col, E_NONE);
            row_next = arow;
            col_next = acol;
          end else begin
            a0        = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b1, start_row, start_col, E_NONE);
            mode_next = M_IDLE;
            fall      = 1'b1;
          end
        end
        M_IDENT, M_CMD: begin
          tkind = (mode == M_IDENT) ? K_IDENT : K_CMD;
          a0v   = 1'b1;
          if (!eoi && is_word(ch)) begin
            a0 = mk(tkind, ch, 1'b1, name_empty, 1'b0, start_row, start_col, E_NONE);
            empty_next = 1'b0;
            row_next   = arow;
            col_next   = acol;
          end else if (name_empty) begin
            a0 = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b0, start_row, start_col,
                    (mode == M_IDENT) ? E_EMPTY_ID : E_EMPTY_CMD);
            halted_next = 1'b1;
          end else begin
            a0        = mk(tkind, 8'd0, 1'b0, 1'b0, 1'b1, start_row, start_col, E_NONE);
            mode_next = M_IDLE;
            fall      = 1'b1;
          end
        end
        M_STR, M_BLOCK: begin
          tkind = (mode == M_STR) ? K_STR : K_BLOCK;
          a0v   = 1'b1;
          if (eoi) begin
            a0 = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b0, cur_row, cur_col,
                    (mode == M_STR) ? E_OPEN_STR : E_OPEN_BLOCK);
            halted_next = 1'b1;
          end else begin
            row_next = arow;
            col_next = acol;
            if (ch == ((mode == M_STR) ? CH_QUOTE : CH_RBRK)) begin
              a0 = mk(tkind, 8'd0, 1'b0, name_empty, 1'b1, start_row, start_col,
                      E_NONE);
              mode_next = M_IDLE;
            end else begin
              a0 = mk(tkind, ch, 1'b1, name_empty, 1'b0, start_row, start_col,
                      E_NONE);
              empty_next = 1'b0;
            end
          end
        end
        M_COLON, M_EQ: begin
          tkind = (mode == M_COLON) ? K_ASSIGN : K_EQU;
          a0v   = 1'b1;
          if (!eoi && ch == CH_EQUAL) begin
            a1v = 1'b1;
            a0  = mk(tkind, held_char, 1'b1, 1'b1, 1'b0, start_row, start_col, E_NONE);
            a1  = mk(tkind, ch, 1'b1, 1'b0, 1'b1, start_row, start_col, E_NONE);
            row_next  = arow;
            col_next  = acol;
            mode_next = M_IDLE;
          end else begin
            a0 = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b0, start_row, start_col,
                    (mode == M_COLON) ? E_BAD_COLON : E_BAD_EQU);
            halted_next = 1'b1;
          end
        end
        M_REL: begin
          a0v       = 1'b1;
          mode_next = M_IDLE;
          if (!eoi && ch == CH_EQUAL) begin
            a0       = mk(K_REL, ch, 1'b1, 1'b0, 1'b1, start_row, start_col, E_NONE);
            row_next = arow;
            col_next = acol;
          end else begin
            a0   = mk(K_REL, 8'd0, 1'b0, 1'b0, 1'b1, start_row, start_col, E_NONE);
            fall = 1'b1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          fall      = 1'b1;
        end
      endcase

      // Byte scanned from idle, or end of file
      if (fall) begin
        bv = 1'b1;
        if (eoi) begin
          b = mk(K_EOF, 8'd0, 1'b0, 1'b1, 1'b1, cur_row, cur_col, E_NONE);
        end else if (is_space(ch)) begin
          bv       = 1'b0;
          row_next = arow;
          col_next = acol;
        end else if (is_digit(ch)) begin
          srow_next  = cur_row;
          scol_next  = cur_col;
          empty_next = 1'b1;
          b          = mk(K_INT, ch, 1'b1, 1'b1, 1'b0, cur_row, cur_col, E_NONE);
          mode_next  = M_INT;
          row_next   = arow;
          col_next   = acol;
        end else begin
          row_next = arow;
          col_next = acol;
          case (ch)
            CH_SEMI: begin
              bv        = 1'b0;
              mode_next = M_COMMENT;
            end
            CH_QUOTE, CH_DOLLAR, CH_AT, CH_LBRK, CH_COLON, CH_EQUAL, CH_BANG: begin
              bv         = 1'b0;
              srow_next  = cur_row;
              scol_next  = cur_col;
              empty_next = 1'b1;
              held_next  = ch;
              case (ch)
                CH_QUOTE:  mode_next = M_STR;
                CH_DOLLAR: mode_next = M_IDENT;
                CH_AT:     mode_next = M_CMD;
                CH_LBRK:   mode_next = M_BLOCK;
                CH_COLON:  mode_next = M_COLON;
                default:   mode_next = M_EQ;
              endcase
              // only the operator openers load the held character
              if (ch == CH_QUOTE || ch == CH_DOLLAR || ch == CH_AT || ch == CH_LBRK) begin
                held_next = held_char;
              end
            end
            CH_LPAREN: b = mk(K_LP, ch, 1'b1, 1'b1, 1'b1, cur_row, cur_col, E_NONE);
            CH_RPAREN: b = mk(K_RP, ch, 1'b1, 1'b1, 1'b1, cur_row, cur_col, E_NONE);
            CH_PLUS, CH_MINUS: begin
              b = mk(K_ADD, ch, 1'b1, 1'b1, 1'b1, cur_row, cur_col, E_NONE);
            end
            CH_STAR, CH_SLASH: begin
              b = mk(K_MUL, ch, 1'b1, 1'b1, 1'b1, cur_row, cur_col, E_NONE);
            end
            CH_LT, CH_GT: begin
              srow_next  = cur_row;
              scol_next  = cur_col;
              empty_next = 1'b1;
              b          = mk(K_REL, ch, 1'b1, 1'b1, 1'b0, cur_row, cur_col, E_NONE);
              mode_next  = M_REL;
            end
            default: begin
              b           = mk(K_INT, 8'd0, 1'b0, 1'b0, 1'b0, cur_row, cur_col,
                               E_BAD_CHAR);
              halted_next = 1'b1;
              row_next    = cur_row;
              col_next    = cur_col;
            end
          endcase
        end
      end
    end
  end

  // Pack records in order into the queue request
  always_comb begin
    push.v0 = go && (a0v || bv);
    push.v1 = go && (a1v || (a0v && bv));
    push.r0 = a0v ? a0 : b;
    push.r1 = a1v ? a1 : b;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      cur_row    <= POS_BITS'(1);
      cur_col    <= POS_BITS'(1);
      start_row  <= POS_BITS'(1);
      start_col  <= POS_BITS'(1);
      held_char  <= 8'd0;
      name_empty <= 1'b1;
      halted     <= 1'b0;
    end else if (go) begin
      mode       <= mode_next;
      cur_row    <= row_next;
      cur_col    <= col_next;
      start_row  <= srow_next;
      start_col  <= scol_next;
      held_char  <= held_next;
      name_empty <= empty_next;
      halted     <= halted_next;
    end
  end

endmodule

>>> rtl/core/token_scanner.sv
// ----------------------------------------------------------------------------
// token_scanner
// Streaming lexer: one source byte per request in, token records out.
// Each byte passes through the input register and then the result queue.
// Throughput: one byte per cycle while the result queue has room for two
// records; the queue drains one record per cycle while the sink is ready.
// Reset (rst, synchronous): idle mode, position row 1 column 1, queue empty,
// halt cleared. After an error the scanner drops all bytes until reset.
// ----------------------------------------------------------------------------
module token_scanner #(
  parameter int POS_BITS = tks_pkg::POS_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tks_char_if.sink   chars,
  tks_tok_if.source  tokens
);
  import tks_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_ch;
  logic       stage_eoi;
  logic       room;
  logic       go;
  push_t      push;

  // Scan the staged byte once the queue can take two records
  assign go          = stage_valid && room;
  assign chars.ready = !stage_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (chars.ready) begin
      stage_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      stage_ch  <= chars.ch;
      stage_eoi <= chars.end_of_input;
    end
  end

  tks_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .ch   (stage_ch),
    .eoi  (stage_eoi),
    .push (push)
  );

  tks_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

>>> test/tb_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_scanner
// Streams source bytes into the token scanner and checks every token record
// against an in-bench lexer, record by record. Directed tokens come first,
// then random well-formed token streams under three idle patterns, a long
// sink hold-off and one closing scan error.
// ----------------------------------------------------------------------------
module tb_token_scanner;
  import tks_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned RUN_BYTES       = 110;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tks_char_if char_bus ();
  tks_tok_if  tok_bus ();

  token_scanner dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (char_bus),
    .tokens (tok_bus)
  );

  always #5 clk = ~clk;

  // Pending source bytes and expected token records
  src_byte_t   src_bytes[$];
  rec_t        expected_recs[$];
  int unsigned bytes_total;
  int unsigned bytes_taken;
  int unsigned recs_checked;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_left;
  bit          hold_go;
  bit          hold_done;
  bit          after_bare_rel;
  logic [2:0]  final_err;
  src_byte_t   next_byte;
  rec_t        got_rec;
  rec_t        want_rec;

  // Lexer state mirrored by the bench
  mode_t       scan_mode;
  logic [15:0] pos_row, pos_col;
  logic [15:0] tok_row, tok_col;
  logic [7:0]  held;
  bit          name_empty;
  bit          scan_halted;
  int unsigned step_recs;

  // ---------------------------------------------------------------------------
  // Lexer model
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_digit(c) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDER;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // At most three records per byte
  function automatic void add_rec(logic [3:0] k, logic [7:0] c, bit has, bit f, bit l,
                                  logic [15:0] r, logic [15:0] cl, logic [2:0] e);
    rec_t x;
    if (step_recs >= 3) return;
    x.kind      = k;
    x.text_char = c;
    x.has_char  = has;
    x.first     = f;
    x.last      = l;
    x.row       = r;
    x.col       = cl;
    x.error     = e;
    expected_recs.insert(expected_recs.size(), x);
    step_recs++;
  endfunction

  function automatic void advance_pos(logic [7:0] c);
    if (c == CH_LF) begin
      if (pos_row != 16'hFFFF) pos_row++;
      pos_col = 16'd1;
    end else if (pos_col != 16'hFFFF) begin
      pos_col++;
    end
  endfunction

  function automatic void halt_with(logic [2:0] code, logic [15:0] r, logic [15:0] cl);
    add_rec(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, r, cl, code);
    scan_halted = 1'b1;
  endfunction

  function automatic void begin_token(mode_t m, logic [7:0] c);
    tok_row    = pos_row;
    tok_col    = pos_col;
    name_empty = 1'b1;
    held       = c;
    scan_mode  = m;
    advance_pos(c);
  endfunction

  function automatic void one_char_token(logic [3:0] k, logic [7:0] c);
    add_rec(k, c, 1'b1, 1'b1, 1'b1, pos_row, pos_col, E_NONE);
    advance_pos(c);
  endfunction

  // Byte seen with no token open
  function automatic void lex_fresh(logic [7:0] c);
    if (is_space(c)) begin
      advance_pos(c);
      return;
    end
    if (c == CH_SEMI) begin
      scan_mode = M_COMMENT;
      advance_pos(c);
      return;
    end
    if (is_digit(c)) begin
      begin_token(M_INT, c);
      add_rec(K_INT, c, 1'b1, 1'b1, 1'b0, tok_row, tok_col, E_NONE);
      return;
    end
    case (c)
      CH_QUOTE:           begin_token(M_STR, c);
      CH_DOLLAR:          begin_token(M_IDENT, c);
      CH_AT:              begin_token(M_CMD, c);
      CH_LBRK:            begin_token(M_BLOCK, c);
      CH_COLON:           begin_token(M_COLON, c);
      CH_EQUAL, CH_BANG:  begin_token(M_EQ, c);
      CH_LPAREN:          one_char_token(K_LP, c);
      CH_RPAREN:          one_char_token(K_RP, c);
      CH_PLUS, CH_MINUS:  one_char_token(K_ADD, c);
      CH_STAR, CH_SLASH:  one_char_token(K_MUL, c);
      CH_LT, CH_GT: begin
        begin_token(M_REL, c);
        add_rec(K_REL, c, 1'b1, 1'b1, 1'b0, tok_row, tok_col, E_NONE);
      end
      default:            halt_with(E_BAD_CHAR, pos_row, pos_col);
    endcase
  endfunction

  // One accepted source byte
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    logic [3:0] k;
    logic [7:0] closer;
    step_recs = 0;
    if (scan_halted) return;
    case (scan_mode)
      M_COMMENT: begin
        if (!eoi) begin
          advance_pos(c);
          if (c == CH_LF) scan_mode = M_IDLE;
          return;
        end
        scan_mode = M_IDLE;
      end
      M_INT: begin
        if (!eoi && is_digit(c)) begin
          add_rec(K_INT, c, 1'b1, 1'b0, 1'b0, tok_row, tok_col, E_NONE);
          advance_pos(c);
          return;
        end
        add_rec(K_INT, 8'h00, 1'b0, 1'b0, 1'b1, tok_row, tok_col, E_NONE);
        scan_mode = M_IDLE;
      end
      M_IDENT, M_CMD: begin
        k = (scan_mode == M_IDENT) ? K_IDENT : K_CMD;
        if (!eoi && is_word(c)) begin
          add_rec(k, c, 1'b1, name_empty, 1'b0, tok_row, tok_col, E_NONE);
          name_empty = 1'b0;
          advance_pos(c);
          return;
        end
        if (name_empty) begin
          halt_with((scan_mode == M_IDENT) ? E_EMPTY_ID : E_EMPTY_CMD, tok_row, tok_col);
          return;
        end
        add_rec(k, 8'h00, 1'b0, 1'b0, 1'b1, tok_row, tok_col, E_NONE);
        scan_mode = M_IDLE;
      end
      M_STR, M_BLOCK: begin
        k      = (scan_mode == M_STR) ? K_STR : K_BLOCK;
        closer = (scan_mode == M_STR) ? CH_QUOTE : CH_RBRK;
        if (eoi) begin
          halt_with((scan_mode == M_STR) ? E_OPEN_STR : E_OPEN_BLOCK, pos_row, pos_col);
          return;
        end
        if (c == closer) begin
          add_rec(k, 8'h00, 1'b0, name_empty, 1'b1, tok_row, tok_col, E_NONE);
          scan_mode = M_IDLE;
        end else begin
          add_rec(k, c, 1'b1, name_empty, 1'b0, tok_row, tok_col, E_NONE);
          name_empty = 1'b0;
        end
        advance_pos(c);
        return;
      end
      M_COLON, M_EQ: begin
        k = (scan_mode == M_COLON) ? K_ASSIGN : K_EQU;
        if (!eoi && c == CH_EQUAL) begin
          add_rec(k, held, 1'b1, 1'b1, 1'b0, tok_row, tok_col, E_NONE);
          add_rec(k, c, 1'b1, 1'b0, 1'b1, tok_row, tok_col, E_NONE);
          advance_pos(c);
          scan_mode = M_IDLE;
          return;
        end
        halt_with((scan_mode == M_COLON) ? E_BAD_COLON : E_BAD_EQU, tok_row, tok_col);
        return;
      end
      M_REL: begin
        if (!eoi && c == CH_EQUAL) begin
          add_rec(K_REL, c, 1'b1, 1'b0, 1'b1, tok_row, tok_col, E_NONE);
          advance_pos(c);
          scan_mode = M_IDLE;
          return;
        end
        add_rec(K_REL, 8'h00, 1'b0, 1'b0, 1'b1, tok_row, tok_col, E_NONE);
        scan_mode = M_IDLE;
      end
      default: scan_mode = M_IDLE;
    endcase
    // the byte that closed a token is scanned again from idle
    if (eoi) begin
      add_rec(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, pos_row, pos_col, E_NONE);
      return;
    end
    lex_fresh(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    src_byte_t x;
    x.ch  = b;
    x.eoi = 1'b0;
    src_bytes.insert(src_bytes.size(), x);
    bytes_total++;
  endtask

  task automatic send_eoi();
    src_byte_t x;
    x.ch  = 8'($urandom_range(0, 255));
    x.eoi = 1'b1;
    src_bytes.insert(src_bytes.size(), x);
    bytes_total++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'(CH_ZERO + r);
    if (r < 36) return 8'(CH_UP_A + r - 10);
    if (r < 62) return 8'(CH_LO_A + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] skip);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == skip);
    return b;
  endfunction

  // One random well-formed token, or filler between tokens
  task automatic send_random_token();
    int unsigned pick, n;
    bit          bare_rel;
    bare_rel       = after_bare_rel;
    after_bare_rel = 1'b0;
    pick           = $urandom_range(0, 11);
    case (pick)
      0: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          // tab through carriage return, or a space
          pick = $urandom_range(0, 5);
          send_byte((pick == 5) ? CH_SPACE : 8'(9 + pick));
        end
      end
      1: begin
        send_byte(CH_SEMI);
        n = $urandom_range(0, 6);
        repeat (n) send_byte(rand_byte_except(CH_LF));
        if ($urandom_range(0, 3) == 0) send_eoi();
        else send_byte(CH_LF);
      end
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      3, 6: begin
        send_byte((pick == 3) ? CH_QUOTE : CH_LBRK);
        n = $urandom_range(0, 5);
        repeat (n) send_byte(rand_byte_except((pick == 3) ? CH_QUOTE : CH_RBRK));
        send_byte((pick == 3) ? CH_QUOTE : CH_RBRK);
      end
      4, 5: begin
        send_byte((pick == 4) ? CH_DOLLAR : CH_AT);
        n = $urandom_range(1, 5);
        repeat (n) send_byte(rand_word_char());
      end
      7: begin
        case ($urandom_range(0, 5))
          0: send_byte(CH_LPAREN);
          1: send_byte(CH_RPAREN);
          2: send_byte(CH_PLUS);
          3: send_byte(CH_MINUS);
          4: send_byte(CH_STAR);
          default: send_byte(CH_SLASH);
        endcase
      end
      8: begin
        send_byte(CH_COLON);
        send_byte(CH_EQUAL);
      end
      9: begin
        if ($urandom_range(0, 1) == 0) begin
          // a lone '<' or '>' would swallow the first '='
          if (bare_rel) send_byte(CH_SPACE);
          send_byte(CH_EQUAL);
        end else begin
          send_byte(CH_BANG);
        end
        send_byte(CH_EQUAL);
      end
      10: begin
        send_byte($urandom_range(0, 1) ? CH_LT : CH_GT);
        if ($urandom_range(0, 1)) send_byte(CH_EQUAL);
        else after_bare_rel = 1'b1;
      end
      default: send_eoi();
    endcase
  endtask

  task automatic send_random_run(int unsigned nbytes);
    int unsigned start;
    start = bytes_total;
    while (bytes_total - start < nbytes) send_random_token();
  endtask

  task automatic wait_all_taken();
    while (bytes_taken != bytes_total) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d field %s got %0h want %0h",
                                recs_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Source driver: predicts each accepted byte, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid        <= 1'b0;
      char_bus.ch           <= 8'h00;
      char_bus.end_of_input <= 1'b0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        lex_byte(char_bus.ch, char_bus.end_of_input);
        bytes_taken++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (src_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_byte              = src_bytes.pop_front();
          char_bus.valid        <= 1'b1;
          char_bus.ch           <= next_byte.ch;
          char_bus.end_of_input <= next_byte.eoi;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token monitor: compares each accepted record with the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tok_bus.ready <= 1'b0;
    end else begin
      if (tok_bus.valid && tok_bus.ready) begin
        got_rec.kind      = tok_bus.kind;
        got_rec.text_char = tok_bus.text_char;
        got_rec.has_char  = tok_bus.has_char;
        got_rec.first     = tok_bus.first;
        got_rec.last      = tok_bus.last;
        got_rec.row       = tok_bus.row;
        got_rec.col       = tok_bus.col;
        got_rec.error     = tok_bus.error;
        if (expected_recs.size() == 0) begin
          report_mismatch($sformatf("record kind %0d error %0d with none pending",
                                    got_rec.kind, got_rec.error));
        end else begin
          want_rec = expected_recs.pop_front();
          check_field("kind", 16'(got_rec.kind), 16'(want_rec.kind));
          check_field("text_char", 16'(got_rec.text_char), 16'(want_rec.text_char));
          check_field("has_char", 16'(got_rec.has_char), 16'(want_rec.has_char));
          check_field("first", 16'(got_rec.first), 16'(want_rec.first));
          check_field("last", 16'(got_rec.last), 16'(want_rec.last));
          check_field("row", got_rec.row, want_rec.row);
          check_field("col", got_rec.col, want_rec.col);
          check_field("error", 16'(got_rec.error), 16'(want_rec.error));
          recs_checked++;
        end
      end
      tok_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Long sink hold-off, started once on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records pending", cycle_cnt,
               expected_recs.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    char_bus.valid        = 1'b0;
    char_bus.ch           = 8'h00;
    char_bus.end_of_input = 1'b0;
    tok_bus.ready         = 1'b0;
    scan_mode   = M_IDLE;
    pos_row     = 16'd1;
    pos_col     = 16'd1;
    tok_row     = 16'd1;
    tok_col     = 16'd1;
    held        = 8'h00;
    name_empty  = 1'b1;
    scan_halted = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, sink mostly stalled
    src_idle_pct  = 9;
    sink_idle_pct = 76;
    // integer closed by end of input, end of input twice
    send_text("09");
    send_eoi();
    send_eoi();
    // string with the extreme byte values, empty name block
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_text("[]");
    // identifier closed by a command sigil, command closed by a colon
    send_text("$_9@Zz:===!=<>=");
    send_text("(-/)");
    send_random_run(RUN_BYTES);
    wait_all_taken();

    // Sender mostly idle, sink mostly ready
    src_idle_pct  = 76;
    sink_idle_pct = 9;
    send_random_run(RUN_BYTES);
    wait_all_taken();

    // No idling; sink holds off while the sender keeps going
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_go       = 1'b1;
    send_random_run(RUN_BYTES);

    // One scan error, then bytes that must be dropped
    final_err = 3'($urandom_range(1, 7));
    send_byte(CH_SPACE);
    case (final_err)
      E_BAD_CHAR:   send_byte($urandom_range(0, 1) ? CH_HASH : 8'($urandom_range(128, 255)));
      E_OPEN_STR: begin
        send_text("\"q");
        send_eoi();
      end
      E_EMPTY_ID:   send_text("$ ");
      E_EMPTY_CMD: begin
        send_byte(CH_AT);
        send_eoi();
      end
      E_OPEN_BLOCK: begin
        send_text("[x");
        send_eoi();
      end
      E_BAD_COLON:  send_text(":x");
      default: begin
        send_byte(CH_BANG);
        send_eoi();
      end
    endcase
    send_text("(1) ");
    send_eoi();

    wait_all_taken();
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("scanned %0d bytes into %0d token records over three idle patterns",
             bytes_taken, recs_checked);
    $display("with a long sink hold-off and closing error %0d", final_err);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
